[sv/imm_pkg.sv]
`timescale 1ns / 1ps

package imm_pkg;

    localparam int MAX_DIM_DEF = 8;
    localparam int DATA_W      = 32;
    localparam int DIM_W       = 4;
    localparam int IDX_W       = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int M_TDATA_W   = 40;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_NEXT,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROWS_A    = 2'd0,
        REG_INNER_DIM = 2'd1,
        REG_COLS_B    = 2'd2
    } cfg_reg_t;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v, input int max_dim);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (int'(v) > max_dim) begin
            r = DIM_W'(max_dim);
        end
        return r;
    endfunction

endpackage

[sv/imm_ram.sv]
`timescale 1ns / 1ps

module imm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/integer_matrix_multiply_core.sv]
`timescale 1ns / 1ps
// Integer matrix multiply core.
// Slave stream: one signed 32-bit element per transfer in s_tdata; s_tuser low
// routes it to matrix A, high to matrix B, each filled in row-major order.
// Elements sent to an already full matrix are dropped.
// Master stream: C = A x B in row-major order, one element per transfer,
// m_tdata = {pad, value, col, row}, m_tlast on the final element of C.
// Dimensions come from the write port (rows_a, inner_dim, cols_b); any write
// to a valid index clears the load counts. 0 acts as 1, above MAX_DIM as MAX_DIM.
// Loading takes an element on each accepted transfer. After the element that
// completes both matrices, the results are computed one at a time by the single
// multiply-accumulate unit, fed by the two operand RAMs through registered reads
// (one read per cycle) and a registered product; the accumulator sums the products.
// s_tready is low while results are computed. When the receiver stalls, the
// result holds in the output register and the next dot product waits for it.
// Reset (synchronous, active low) sets all dimensions to 8, clears the load
// counts and empties the output register; RAM contents are not cleared.
module integer_matrix_multiply_core #(
    parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [imm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [imm_pkg::DIM_W-1:0]      cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [imm_pkg::DATA_W-1:0]     s_tdata,   // element_value
    input  logic                           s_tuser,   // to_matrix_b
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [imm_pkg::M_TDATA_W-1:0]  m_tdata,   // result_row, result_col, result_value
    output logic                           m_tlast
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DW     = imm_pkg::DATA_W;
    localparam int XW     = imm_pkg::DIM_W;
    localparam int IW     = imm_pkg::IDX_W;

    imm_pkg::state_t state_reg, state_next;

    logic [XW-1:0]     rows_reg, rows_next;
    logic [XW-1:0]     inner_reg, inner_next;
    logic [XW-1:0]     cols_reg, cols_next;
    logic [CNT_W-1:0]  cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0]  cnt_b_reg, cnt_b_next;
    logic [IW-1:0]     i_reg, i_next;
    logic [IW-1:0]     j_reg, j_next;
    logic [IW-1:0]     k_reg, k_next;
    logic [ADDR_W-1:0] a_base_reg, a_base_next;
    logic [ADDR_W-1:0] a_addr_reg, a_addr_next;
    logic [ADDR_W-1:0] b_addr_reg, b_addr_next;

    logic              rd_v_reg, rd_first_reg, rd_last_reg;
    logic              pr_v_reg, pr_first_reg, pr_last_reg;
    logic [DW-1:0]     prod_reg;
    logic [DW-1:0]     acc_reg, acc_next;

    logic              out_v_reg, out_v_next;
    logic [IW-1:0]     out_row_reg, out_row_next;
    logic [IW-1:0]     out_col_reg, out_col_next;
    logic [DW-1:0]     out_val_reg, out_val_next;
    logic              out_last_reg, out_last_next;

    logic [XW-1:0]     dim_m, dim_n, dim_p;
    logic [CNT_W-1:0]  size_a, size_b;
    logic              s_fire, we_a, we_b;
    logic              iss_v, iss_first, iss_last;
    logic              last_elem;
    logic [DW-1:0]     acc_sum;
    logic [DW-1:0]     a_rdata, b_rdata;

    assign dim_m  = imm_pkg::eff_dim(rows_reg, MAX_DIM);
    assign dim_n  = imm_pkg::eff_dim(inner_reg, MAX_DIM);
    assign dim_p  = imm_pkg::eff_dim(cols_reg, MAX_DIM);
    assign size_a = CNT_W'(dim_m * dim_n);
    assign size_b = CNT_W'(dim_n * dim_p);

    assign s_tready = (state_reg == imm_pkg::ST_LOAD);
    assign s_fire   = s_tvalid && s_tready;
    assign we_a     = s_fire && !s_tuser && (cnt_a_reg < size_a);
    assign we_b     = s_fire && s_tuser && (cnt_b_reg < size_b);

    assign iss_v     = (state_reg == imm_pkg::ST_ISSUE);
    assign iss_first = (k_reg == '0);
    assign iss_last  = ({1'b0, k_reg} == (dim_n - XW'(1)));
    assign last_elem = ({1'b0, i_reg} == (dim_m - XW'(1)))
                    && ({1'b0, j_reg} == (dim_p - XW'(1)));
    assign acc_sum   = (pr_first_reg ? '0 : acc_reg) + prod_reg;

    imm_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram_a (
        .aclk  (aclk),
        .we    (we_a),
        .waddr (cnt_a_reg[ADDR_W-1:0]),
        .wdata (s_tdata),
        .raddr (a_addr_reg),
        .rdata (a_rdata)
    );

    imm_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram_b (
        .aclk  (aclk),
        .we    (we_b),
        .waddr (cnt_b_reg[ADDR_W-1:0]),
        .wdata (s_tdata),
        .raddr (b_addr_reg),
        .rdata (b_rdata)
    );

    always_comb begin
        state_next    = state_reg;
        rows_next     = rows_reg;
        inner_next    = inner_reg;
        cols_next     = cols_reg;
        cnt_a_next    = cnt_a_reg;
        cnt_b_next    = cnt_b_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        a_base_next   = a_base_reg;
        a_addr_next   = a_addr_reg;
        b_addr_next   = b_addr_reg;
        acc_next      = acc_reg;
        out_v_next    = out_v_reg && !m_tready;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_val_next  = out_val_reg;
        out_last_next = out_last_reg;

        if (pr_v_reg) begin
            acc_next = acc_sum;
        end

        unique case (state_reg)
            imm_pkg::ST_LOAD: begin
                if (we_a) begin
                    cnt_a_next = cnt_a_reg + CNT_W'(1);
                end
                if (we_b) begin
                    cnt_b_next = cnt_b_reg + CNT_W'(1);
                end
                if ((we_a || we_b) && (cnt_a_next >= size_a) && (cnt_b_next >= size_b)) begin
                    state_next  = imm_pkg::ST_NEXT;
                    i_next      = '0;
                    j_next      = '0;
                    a_base_next = '0;
                end
            end
            imm_pkg::ST_NEXT: begin
                if (!out_v_reg || m_tready) begin
                    state_next  = imm_pkg::ST_ISSUE;
                    k_next      = '0;
                    a_addr_next = a_base_reg;
                    b_addr_next = ADDR_W'(j_reg);
                end
            end
            imm_pkg::ST_ISSUE: begin
                k_next      = k_reg + IW'(1);
                a_addr_next = a_addr_reg + ADDR_W'(1);
                b_addr_next = ADDR_W'(b_addr_reg + dim_p);
                if (iss_last) begin
                    state_next = imm_pkg::ST_DRAIN;
                end
            end
            imm_pkg::ST_DRAIN: begin
                if (pr_v_reg && pr_last_reg) begin
                    out_v_next    = 1'b1;
                    out_row_next  = i_reg;
                    out_col_next  = j_reg;
                    out_val_next  = acc_sum;
                    out_last_next = last_elem;
                    if (last_elem) begin
                        state_next = imm_pkg::ST_LOAD;
                        cnt_a_next = '0;
                        cnt_b_next = '0;
                    end else begin
                        state_next = imm_pkg::ST_NEXT;
                        if ({1'b0, j_reg} == (dim_p - XW'(1))) begin
                            j_next      = '0;
                            i_next      = i_reg + IW'(1);
                            a_base_next = ADDR_W'(a_base_reg + dim_n);
                        end else begin
                            j_next = j_reg + IW'(1);
                        end
                    end
                end
            end
            default: begin
                state_next = imm_pkg::ST_LOAD;
            end
        endcase

        if (cfg_we) begin
            unique case (imm_pkg::cfg_reg_t'(cfg_index))
                imm_pkg::REG_ROWS_A: begin
                    rows_next  = cfg_wdata;
                    cnt_a_next = '0;
                    cnt_b_next = '0;
                end
                imm_pkg::REG_INNER_DIM: begin
                    inner_next = cfg_wdata;
                    cnt_a_next = '0;
                    cnt_b_next = '0;
                end
                imm_pkg::REG_COLS_B: begin
                    cols_next  = cfg_wdata;
                    cnt_a_next = '0;
                    cnt_b_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= imm_pkg::ST_LOAD;
            rows_reg     <= XW'(8);
            inner_reg    <= XW'(8);
            cols_reg     <= XW'(8);
            cnt_a_reg    <= '0;
            cnt_b_reg    <= '0;
            rd_v_reg     <= 1'b0;
            pr_v_reg     <= 1'b0;
            out_v_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rows_reg     <= rows_next;
            inner_reg    <= inner_next;
            cols_reg     <= cols_next;
            cnt_a_reg    <= cnt_a_next;
            cnt_b_reg    <= cnt_b_next;
            rd_v_reg     <= iss_v;
            pr_v_reg     <= rd_v_reg;
            out_v_reg    <= out_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        a_base_reg   <= a_base_next;
        a_addr_reg   <= a_addr_next;
        b_addr_reg   <= b_addr_next;
        rd_first_reg <= iss_first;
        rd_last_reg  <= iss_last;
        pr_first_reg <= rd_first_reg;
        pr_last_reg  <= rd_last_reg;
        prod_reg     <= DW'(a_rdata * b_rdata);
        acc_reg      <= acc_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {{(imm_pkg::M_TDATA_W - DW - 2 * IW){1'b0}},
                       out_val_reg, out_col_reg, out_row_reg};
    assign m_tlast  = out_last_reg;

endmodule

[sv/imm_checker.sv]
`timescale 1ns / 1ps

module imm_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [imm_pkg::M_TDATA_W-1:0]  m_tdata,
    input logic                           m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared right after a load transfer");

    a_last_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("result follows the final element without a new run");

endmodule

bind integer_matrix_multiply_core imm_checker u_imm_checker (.*);
